@@ hdl/uart_rx_fifo_xon_xoff_top_assert.svh @@
// Assertion macros for the UART receive FIFO with XON/XOFF flow control.
// Included by the top level; expects a clock named clk and a reset named rst.
`ifndef UART_RX_FIFO_XON_XOFF_TOP_ASSERT_SVH
`define UART_RX_FIFO_XON_XOFF_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define URXF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("urxf: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define URXF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("urxf: next-cycle check failed");

`endif

@@ hdl/urxf_pkg.sv @@
// Shared types and constants for the UART receive FIFO with XON/XOFF.
// No dependencies; used by every module of the block.
package urxf_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int LVL_W  = 7;
  localparam int CMP_W  = (CNT_W > LVL_W) ? CNT_W : LVL_W;
  localparam int PADDR_W = 4;

  localparam logic ACT_RX   = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [1:0] {
    REG_XON_CHAR   = 2'd0,
    REG_XOFF_CHAR  = 2'd1,
    REG_XOFF_LEVEL = 2'd2,
    REG_XON_LEVEL  = 2'd3
  } reg_idx_t;

  localparam logic [7:0]       XON_RESET   = 8'd17;
  localparam logic [7:0]       XOFF_RESET  = 8'd19;
  localparam logic [LVL_W-1:0] XOFF_LVL_RESET = 7'd5;
  localparam logic [LVL_W-1:0] XON_LVL_RESET  = 7'd54;

  typedef struct packed {
    logic       action;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]       read_data;
    logic             read_valid;
    logic             flow_send;
    logic [7:0]       flow_byte;
    logic             peer_allows_tx;
    logic [LVL_W-1:0] free_space;
    logic             overflow;
  } out_t;

  typedef struct packed {
    logic [7:0]       xon_char;
    logic [7:0]       xoff_char;
    logic [LVL_W-1:0] xoff_free_level;
    logic [LVL_W-1:0] xon_free_level;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage

@@ hdl/urxf_ram.sv @@
// Byte store of the receive FIFO: one write port, one read port, registered read.
// Depends on urxf_pkg for depth and request struct.
module urxf_ram (
  input  logic              clk,
  input  urxf_pkg::ram_req_t req,
  output logic [7:0]        rdata
);

  logic [7:0] mem [urxf_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ hdl/urxf_regs.sv @@
// APB configuration registers: XON/XOFF characters and free-space levels.
// Depends on urxf_pkg for the register map and config struct.
module urxf_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [urxf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output urxf_pkg::cfg_t              cfg
);

  logic                  wr;
  urxf_pkg::reg_idx_t    idx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = urxf_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.xon_char        <= urxf_pkg::XON_RESET;
      cfg.xoff_char       <= urxf_pkg::XOFF_RESET;
      cfg.xoff_free_level <= urxf_pkg::XOFF_LVL_RESET;
      cfg.xon_free_level  <= urxf_pkg::XON_LVL_RESET;
    end else if (wr) begin
      case (idx)
        urxf_pkg::REG_XON_CHAR:   cfg.xon_char        <= pwdata[7:0];
        urxf_pkg::REG_XOFF_CHAR:  cfg.xoff_char       <= pwdata[7:0];
        urxf_pkg::REG_XOFF_LEVEL: cfg.xoff_free_level <= pwdata[urxf_pkg::LVL_W-1:0];
        urxf_pkg::REG_XON_LEVEL:  cfg.xon_free_level  <= pwdata[urxf_pkg::LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      urxf_pkg::REG_XON_CHAR:   prdata = {24'd0, cfg.xon_char};
      urxf_pkg::REG_XOFF_CHAR:  prdata = {24'd0, cfg.xoff_char};
      urxf_pkg::REG_XOFF_LEVEL: prdata = {25'd0, cfg.xoff_free_level};
      urxf_pkg::REG_XON_LEVEL:  prdata = {25'd0, cfg.xon_free_level};
      default:                  prdata = 32'd0;
    endcase
  end

endmodule

@@ hdl/urxf_ctrl.sv @@
// FIFO control: pointers, free count, flow-control flags, result pipeline.
// Depends on urxf_pkg; drives the byte store through a ram_req_t struct.
module urxf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  urxf_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  urxf_pkg::in_t      in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output urxf_pkg::out_t     out_data,
  output urxf_pkg::ram_req_t ram_req,
  input  logic [7:0]         ram_rdata
);

  localparam int AW = urxf_pkg::ADDR_W;
  localparam int CW = urxf_pkg::CNT_W;
  localparam int MW = urxf_pkg::CMP_W;
  localparam logic [AW-1:0] LAST_PTR  = AW'(urxf_pkg::DEPTH - 1);
  localparam logic [CW-1:0] FULL_FREE = CW'(urxf_pkg::DEPTH);

  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [CW-1:0] free_cnt, free_cnt_next;
  logic          local_tx_on, local_tx_on_next;
  logic          remote_allows, remote_allows_next;

  // Stage between accept and output: result fields waiting for RAM read data.
  logic           p_valid;
  urxf_pkg::out_t p_res, p_res_next;

  logic accept, advance;

  assign advance  = !out_valid || out_ready;
  assign in_ready = !p_valid || advance;
  assign accept   = in_valid && in_ready;

  always_comb begin
    rd_ptr_next        = rd_ptr;
    wr_ptr_next        = wr_ptr;
    free_cnt_next      = free_cnt;
    local_tx_on_next   = local_tx_on;
    remote_allows_next = remote_allows;
    p_res_next         = '0;
    ram_req            = '0;
    ram_req.waddr      = wr_ptr;
    ram_req.wdata      = in_data.rx_byte;
    ram_req.raddr      = rd_ptr;

    if (in_data.action == urxf_pkg::ACT_RX) begin
      if (in_data.rx_byte == cfg.xoff_char) begin
        remote_allows_next = 1'b0;
      end else if (in_data.rx_byte == cfg.xon_char) begin
        remote_allows_next = 1'b1;
      end else if (free_cnt == '0) begin
        p_res_next.overflow = 1'b1;
      end else begin
        ram_req.we    = accept;
        wr_ptr_next   = (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
        free_cnt_next = free_cnt - 1'b1;
        if (local_tx_on && MW'(free_cnt_next) <= MW'(cfg.xoff_free_level)) begin
          local_tx_on_next     = 1'b0;
          p_res_next.flow_send = 1'b1;
          p_res_next.flow_byte = cfg.xoff_char;
        end
      end
    end else begin
      if (free_cnt < FULL_FREE) begin
        ram_req.re            = accept;
        p_res_next.read_valid = 1'b1;
        rd_ptr_next   = (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
        free_cnt_next = free_cnt + 1'b1;
        if (!local_tx_on && MW'(free_cnt_next) >= MW'(cfg.xon_free_level)) begin
          local_tx_on_next     = 1'b1;
          p_res_next.flow_send = 1'b1;
          p_res_next.flow_byte = cfg.xon_char;
        end
      end
    end

    p_res_next.peer_allows_tx = remote_allows_next;
    p_res_next.free_space     = urxf_pkg::LVL_W'(free_cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr        <= '0;
      wr_ptr        <= '0;
      free_cnt      <= FULL_FREE;
      local_tx_on   <= 1'b1;
      remote_allows <= 1'b1;
      p_valid       <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (accept) begin
        rd_ptr        <= rd_ptr_next;
        wr_ptr        <= wr_ptr_next;
        free_cnt      <= free_cnt_next;
        local_tx_on   <= local_tx_on_next;
        remote_allows <= remote_allows_next;
      end
      if (in_ready) begin
        p_valid <= accept;
      end
      if (advance) begin
        out_valid <= p_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      p_res <= p_res_next;
    end
    // RAM read data is held while the stage stalls, since no new read is issued.
    if (advance && p_valid) begin
      out_data           <= p_res;
      out_data.read_data <= p_res.read_valid ? ram_rdata : 8'd0;
    end
  end

endmodule

@@ hdl/uart_rx_fifo_xon_xoff_top.sv @@
// Top level of the UART receive FIFO with XON/XOFF software flow control.
// Depends on urxf_pkg, urxf_regs, urxf_ctrl, urxf_ram and the assertion header.
//
// Usage:
//   in channel (in_valid/in_ready/in_data): one item per line byte received
//   (action = 0) or per software read (action = 1).
//   out channel (out_valid/out_ready/out_data): exactly one result item per
//   input item, in order: popped byte, flow-control request, peer flag,
//   free space and overflow flag.
//   APB port: XON/XOFF characters and free-space levels at 0x0, 0x4, 0x8, 0xC.
//   Write them only while no item is in flight.
// Timing: an accepted item goes to the result stage and then to the output
//   register; the byte store is a 64-entry RAM with a registered read, and a
//   single access per item lets it take one item every cycle unless stalled.
// Reset: pointers cleared, free space 64, both flow flags set, registers at
//   their defaults; store contents are not cleared and need no sweep.
// Stall: when out_ready is low, the result and one item behind it are held,
//   and in_ready drops once that item is held, until the output is taken.
module uart_rx_fifo_xon_xoff_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  urxf_pkg::in_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output urxf_pkg::out_t              out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [urxf_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  `include "uart_rx_fifo_xon_xoff_top_assert.svh"

  urxf_pkg::cfg_t     cfg;
  urxf_pkg::ram_req_t ram_req;
  logic [7:0]         ram_rdata;

  urxf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  urxf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .ram_req   (ram_req),
    .ram_rdata (ram_rdata)
  );

  urxf_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  // A read with nothing popped returns zero.
  `URXF_ASSERT_IMPL(a_rdata_zero, out_valid && !out_data.read_valid, out_data.read_data == 8'd0)
  // A pop and a dropped byte never come from the same item.
  `URXF_ASSERT_IMPL(a_pop_not_ovf, out_valid && out_data.read_valid, !out_data.overflow)
  // No flow byte without a send request.
  `URXF_ASSERT_IMPL(a_fbyte_zero, out_valid && !out_data.flow_send, out_data.flow_byte == 8'd0)
  // Hold a waiting result unchanged until it is taken.
  `URXF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for uart_rx_fifo_xon_xoff_top: line bytes and reads go in,
// and each result is checked against a behavioral copy of the ring buffer.
// Depends on urxf_pkg and the top level RTL.
module testbench;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  urxf_pkg::in_t in_data;
  logic out_valid;
  logic out_ready;
  urxf_pkg::out_t out_data;
  logic psel;
  logic penable;
  logic pwrite;
  logic [urxf_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  // Behavioral copy of the buffer, its flow flags and its registers
  logic [7:0] byte_store [urxf_pkg::DEPTH];
  int head_ptr;
  int tail_ptr;
  int free_slots;
  logic local_on;
  logic peer_ok;
  logic [7:0] cfg_xon;
  logic [7:0] cfg_xoff;
  logic [urxf_pkg::LVL_W-1:0] cfg_xoff_lvl;
  logic [urxf_pkg::LVL_W-1:0] cfg_xon_lvl;

  urxf_pkg::out_t pending_results[$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  uart_rx_fifo_xon_xoff_top dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic urxf_pkg::out_t next_rx_result(urxf_pkg::in_t item);
    urxf_pkg::out_t r;
    r = '0;
    if (item.action == urxf_pkg::ACT_RX) begin
      // XOFF wins when both characters are the same
      if (item.rx_byte == cfg_xoff) begin
        peer_ok = 1'b0;
      end else if (item.rx_byte == cfg_xon) begin
        peer_ok = 1'b1;
      end else if (free_slots == 0) begin
        r.overflow = 1'b1;
      end else begin
        byte_store[tail_ptr] = item.rx_byte;
        tail_ptr = (tail_ptr + 1) % urxf_pkg::DEPTH;
        free_slots--;
        if (local_on && free_slots <= cfg_xoff_lvl) begin
          local_on = 1'b0;
          r.flow_send = 1'b1;
          r.flow_byte = cfg_xoff;
        end
      end
    end else if (free_slots < urxf_pkg::DEPTH) begin
      r.read_data = byte_store[head_ptr];
      r.read_valid = 1'b1;
      head_ptr = (head_ptr + 1) % urxf_pkg::DEPTH;
      free_slots++;
      if (!local_on && free_slots >= cfg_xon_lvl) begin
        local_on = 1'b1;
        r.flow_send = 1'b1;
        r.flow_byte = cfg_xon;
      end
    end
    r.peer_allows_tx = peer_ok;
    r.free_space = urxf_pkg::LVL_W'(free_slots);
    return r;
  endfunction

  // Random line byte that is neither flow control character
  function automatic logic [7:0] data_byte();
    logic [7:0] b;
    b = 8'($urandom_range(255));
    while (b == cfg_xon || b == cfg_xoff) b = 8'($urandom_range(255));
    return b;
  endfunction

  always @(posedge clk) begin : watch_ports
    urxf_pkg::out_t want;
    out_ready <= ($urandom_range(99) >= stall_pct);
    if (!rst) begin
      if (in_valid && in_ready) pending_results.push_back(next_rx_result(in_data));
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no item outstanding: %p", out_data);
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (out_data.read_data !== want.read_data) begin
            $error("read_data: expected %0h, got %0h", want.read_data, out_data.read_data);
            errors++;
          end
          if (out_data.read_valid !== want.read_valid) begin
            $error("read_valid: expected %0b, got %0b", want.read_valid, out_data.read_valid);
            errors++;
          end
          if (out_data.flow_send !== want.flow_send) begin
            $error("flow_send: expected %0b, got %0b", want.flow_send, out_data.flow_send);
            errors++;
          end
          if (out_data.flow_byte !== want.flow_byte) begin
            $error("flow_byte: expected %0h, got %0h", want.flow_byte, out_data.flow_byte);
            errors++;
          end
          if (out_data.peer_allows_tx !== want.peer_allows_tx) begin
            $error("peer_allows_tx: expected %0b, got %0b", want.peer_allows_tx,
                   out_data.peer_allows_tx);
            errors++;
          end
          if (out_data.free_space !== want.free_space) begin
            $error("free_space: expected %0d, got %0d", want.free_space, out_data.free_space);
            errors++;
          end
          if (out_data.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, out_data.overflow);
            errors++;
          end
        end
      end
    end
  end

  // Hold valid across back-to-back items; drop it only while idling
  task automatic send_item(input logic act, input logic [7:0] rx);
    urxf_pkg::in_t item;
    item.action = act;
    item.rx_byte = rx;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  // Wait for a clock edge first so the last accepted item is already queued
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Keep psel high between writes; the caller releases the bus
  task automatic write_reg(input urxf_pkg::reg_idx_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= urxf_pkg::PADDR_W'(4 * idx);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      urxf_pkg::REG_XON_CHAR: cfg_xon = value[7:0];
      urxf_pkg::REG_XOFF_CHAR: cfg_xoff = value[7:0];
      urxf_pkg::REG_XOFF_LEVEL: cfg_xoff_lvl = value[urxf_pkg::LVL_W-1:0];
      urxf_pkg::REG_XON_LEVEL: cfg_xon_lvl = value[urxf_pkg::LVL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] xon, input logic [7:0] xoff,
                                input logic [urxf_pkg::LVL_W-1:0] xoff_lvl,
                                input logic [urxf_pkg::LVL_W-1:0] xon_lvl);
    drain_results();
    write_reg(urxf_pkg::REG_XON_CHAR, 32'(xon));
    write_reg(urxf_pkg::REG_XOFF_CHAR, 32'(xoff));
    write_reg(urxf_pkg::REG_XOFF_LEVEL, 32'(xoff_lvl));
    write_reg(urxf_pkg::REG_XON_LEVEL, 32'(xon_lvl));
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Empty read, extreme data values, both flow characters, reads past empty
  task automatic test_basic_items();
    send_item(urxf_pkg::ACT_READ, 8'($urandom_range(255)));
    send_item(urxf_pkg::ACT_RX, 8'h00);
    send_item(urxf_pkg::ACT_RX, 8'hFF);
    send_item(urxf_pkg::ACT_RX, 8'h7F);
    send_item(urxf_pkg::ACT_RX, 8'h80);
    send_item(urxf_pkg::ACT_RX, urxf_pkg::XOFF_RESET);
    send_item(urxf_pkg::ACT_RX, 8'h01);
    send_item(urxf_pkg::ACT_RX, urxf_pkg::XON_RESET);
    repeat (6) send_item(urxf_pkg::ACT_READ, 8'hFF);
  endtask

  // A byte matching both characters acts as XOFF
  task automatic test_matching_chars();
    apply_settings(8'h55, 8'h55, urxf_pkg::XOFF_LVL_RESET, urxf_pkg::XON_LVL_RESET);
    send_item(urxf_pkg::ACT_RX, 8'h55);
    send_item(urxf_pkg::ACT_RX, 8'hAA);
    send_item(urxf_pkg::ACT_RX, 8'h55);
    send_item(urxf_pkg::ACT_READ, 8'h00);
  endtask

  // Pause the peer, fill past full, resume, then drain past empty
  task automatic test_fill_and_drain();
    apply_settings(urxf_pkg::XON_RESET, urxf_pkg::XOFF_RESET,
                   urxf_pkg::XOFF_LVL_RESET, urxf_pkg::XON_LVL_RESET);
    send_item(urxf_pkg::ACT_RX, urxf_pkg::XOFF_RESET);
    repeat (urxf_pkg::DEPTH + 2) send_item(urxf_pkg::ACT_RX, data_byte());
    send_item(urxf_pkg::ACT_RX, urxf_pkg::XON_RESET);
    repeat (urxf_pkg::DEPTH + 2) send_item(urxf_pkg::ACT_READ, 8'($urandom_range(255)));
  endtask

  // Runs of mostly pushes or mostly reads sweep the fill level end to end
  task automatic run_random(input int count);
    int push_pct;
    int run_left;
    logic act;
    logic [7:0] rx;
    push_pct = 50;
    run_left = 0;
    for (int n = 0; n < count; n++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(80, 5);
        case ($urandom_range(2))
          0: push_pct = 90;
          1: push_pct = 10;
          default: push_pct = 50;
        endcase
      end
      run_left--;
      act = ($urandom_range(99) < push_pct) ? urxf_pkg::ACT_RX : urxf_pkg::ACT_READ;
      case ($urandom_range(19))
        0: rx = cfg_xon;
        1: rx = cfg_xoff;
        default: rx = 8'($urandom_range(255));
      endcase
      send_item(act, rx);
    end
  endtask

  task automatic test_random_phases();
    int idle_tab [4];
    int stall_tab [4];
    idle_tab = '{0, 79, 0, 34};
    stall_tab = '{0, 0, 79, 34};
    for (int i = 0; i < 8; i++) begin
      case (i)
        0: apply_settings(urxf_pkg::XON_RESET, urxf_pkg::XOFF_RESET,
                          urxf_pkg::XOFF_LVL_RESET, urxf_pkg::XON_LVL_RESET);
        1: apply_settings(8'h00, 8'hFF, 7'd0, 7'd64);
        2: apply_settings(8'hFF, 8'h00, 7'd64, 7'd0);
        3: apply_settings(8'h55, 8'h55, 7'd127, 7'd127);
        4: apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)), 7'd10, 7'd20);
        5: apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                          7'($urandom_range(64)), 7'($urandom_range(64)));
        6: apply_settings(8'hAA, 8'h0F, 7'd32, 7'd33);
        default: apply_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
                                7'($urandom_range(127)), 7'($urandom_range(127)));
      endcase
      idle_pct = idle_tab[i % 4];
      stall_pct = stall_tab[i % 4];
      run_random(250);
    end
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    head_ptr = 0;
    tail_ptr = 0;
    free_slots = urxf_pkg::DEPTH;
    local_on = 1'b1;
    peer_ok = 1'b1;
    cfg_xon = urxf_pkg::XON_RESET;
    cfg_xoff = urxf_pkg::XOFF_RESET;
    cfg_xoff_lvl = urxf_pkg::XOFF_LVL_RESET;
    cfg_xon_lvl = urxf_pkg::XON_LVL_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_basic_items();
    test_matching_chars();
    test_fill_and_drain();
    test_random_phases();

    drain_results();
    repeat (6) @(posedge clk);
    if (pending_results.size() != 0) begin
      $error("results outstanding at end: expected 0, got %0d", pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("** uart_rx_fifo_xon_xoff_top: PASSED **");
    end else begin
      $display("** uart_rx_fifo_xon_xoff_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("** uart_rx_fifo_xon_xoff_top: FAILED **");
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/urxf_pkg.sv
hdl/urxf_ram.sv
hdl/urxf_regs.sv
hdl/urxf_ctrl.sv
hdl/uart_rx_fifo_xon_xoff_top.sv
verif/testbench.sv
